// ----- rtl/core/sate_pkg.sv -----
package sate_pkg;

   // default geometry
   localparam int DEF_IMAGE_WIDTH  = 512;
   localparam int DEF_IMAGE_HEIGHT = 512;
   localparam int DEF_SENSE_WINDOW = 2;

   // request kinds
   localparam logic [1:0] REQ_STEP = 2'd0;
   localparam logic [1:0] REQ_EVAP = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // random turn codes
   localparam logic [1:0] TURN_POS = 2'd1;
   localparam logic [1:0] TURN_NEG = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DECAY  = 2'd0;
   localparam logic [1:0] CSR_SENSOR = 2'd1;
   localparam logic [1:0] CSR_BG     = 2'd2;

   // register reset values
   localparam logic [16:0] DECAY_RESET  = 17'd65339;
   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [4:0]  SENSOR_RESET = 5'd8;
   localparam logic [23:0] BG_RESET     = 24'd0;

   // fixed point constants
   localparam logic signed [15:0] ROT_COS = 16'sd30274;
   localparam logic signed [15:0] ROT_SIN = 16'sd12540;
   localparam logic signed [8:0]  DIAG_Q8 = 9'sd181;
   localparam logic [31:0]        SLOW_SQ = 32'd16777216;

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      logic signed [15:0] r;
      if (v > 34'sd32767) r = 16'sh7fff;
      else if (v < -34'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ----- rtl/core/sate_ifs.sv -----
interface sate_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [16:0]        pos_x;
   logic [16:0]        pos_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic [23:0]        agent_color;
   logic [1:0]         turn_choice;
   logic signed [14:0] random_vx;
   logic signed [14:0] random_vy;
   logic [8:0]         pixel_x;
   logic [8:0]         pixel_y;
   modport source(output valid, req_type, pos_x, pos_y, vel_x, vel_y, agent_color,
                  turn_choice, random_vx, random_vy, pixel_x, pixel_y, input ready);
   modport sink(input valid, req_type, pos_x, pos_y, vel_x, vel_y, agent_color,
                turn_choice, random_vx, random_vy, pixel_x, pixel_y, output ready);
endinterface

interface sate_rsp_if;
   logic               valid;
   logic               ready;
   logic [16:0]        new_pos_x;
   logic [16:0]        new_pos_y;
   logic signed [15:0] new_vel_x;
   logic signed [15:0] new_vel_y;
   logic [23:0]        pixel_color;
   modport source(output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, pixel_color,
                  input ready);
   modport sink(input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, pixel_color,
                output ready);
endinterface

interface sate_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [23:0] data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface

// ----- rtl/core/sate_ram.sv -----
module sate_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/sate_ratio.sv -----
// per-channel quotient of a pixel by the swarm colour, one quotient bit a cycle
module sate_ratio import sate_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] pixel,
   input  logic [23:0] favor,
   output logic        done,
   output logic        match
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] num_ff [3];
   logic [7:0] num_in [3];
   logic [7:0] den_ff [3];
   logic [7:0] den_in [3];
   logic [7:0] rem_ff [3];
   logic [7:0] rem_in [3];
   logic [7:0] quo_ff [3];
   logic [7:0] quo_in [3];
   logic [8:0] trial  [3];
   logic [7:0] quo_eff [3];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = busy_ff && (step_ff == 3'd7);
      for (int i = 0; i < 3; i++) begin
         num_in[i] = num_ff[i];
         den_in[i] = den_ff[i];
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
         trial[i]  = {rem_ff[i], num_ff[i][7]};
         quo_eff[i] = (den_ff[i] == 8'd0) ? 8'd0 : quo_ff[i];
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         for (int i = 0; i < 3; i++) begin
            num_in[i] = pixel[8*i +: 8];
            den_in[i] = favor[8*i +: 8];
            rem_in[i] = 8'd0;
            quo_in[i] = 8'd0;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
         end
         for (int i = 0; i < 3; i++) begin
            num_in[i] = {num_ff[i][6:0], 1'b0};
            if (trial[i] >= {1'b0, den_ff[i]}) begin
               rem_in[i] = 8'(trial[i] - {1'b0, den_ff[i]});
               quo_in[i] = {quo_ff[i][6:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][7:0];
               quo_in[i] = {quo_ff[i][6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done  = done_ff;
   assign match = (quo_eff[0] == quo_eff[1]) && (quo_eff[1] == quo_eff[2]);

endmodule

// ----- rtl/core/slime_agent_trail_engine.sv -----
// slime agent trail engine: trail image in one synchronous ram, agent step,
// evaporate pass and pixel read served one request at a time
//
// req_ch: request channel, valid/ready; req_type picks agent step, evaporate
//   or pixel read; request type three returns an all-zero response
// rsp_ch: one response per request, held in an output register; the next
//   request is taken while that response still waits for ready
// csr_ch: register writes (decay rate, sensor length, background), always ready
// response time is set by the single ram port pair and the serial divider:
//   an agent step finds the sensor distance, wraps the sensor points, then
//   scores both DIM by DIM sensor windows pixel by pixel, running the divider
//   only where a window pixel differs from the background; a pixel read wraps
//   and reads one pixel; wrap moves each coordinate by one image size per pass
//   until all lie inside the image; the evaporate pass decays every interior
//   pixel, one pixel a cycle
// the next request is accepted in the idle cycle after a response is loaded,
//   so the engine takes no new request before the last one is finished
// reset: the ram is swept to the reset background, one pixel a cycle;
//   requests wait, register writes do not
// a stalled receiver holds the finished response; the engine then waits in
//   its done state before returning to idle
module slime_agent_trail_engine import sate_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
   parameter int SENSE_WINDOW = DEF_SENSE_WINDOW
) (
   input logic         clock,
   input logic         reset,
   sate_req_if.sink    req_ch,
   sate_rsp_if.source  rsp_ch,
   sate_csr_if.sink    csr_ch
);

   localparam int XW    = $clog2(IMAGE_WIDTH);
   localparam int YW    = $clog2(IMAGE_HEIGHT);
   localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int HALF  = SENSE_WINDOW / 2;
   localparam int DIM   = 2 * HALF + 1;
   localparam int OW    = $clog2(DIM);
   localparam int CW    = 12;
   localparam logic signed [CW-1:0] WS     = CW'(IMAGE_WIDTH);
   localparam logic signed [CW-1:0] HS     = CW'(IMAGE_HEIGHT);
   localparam logic signed [CW-1:0] HALF_S = CW'(HALF);
   localparam logic signed [23:0]   LIM_X  = 24'((IMAGE_WIDTH - 1) * 256);
   localparam logic signed [23:0]   LIM_Y  = 24'((IMAGE_HEIGHT - 1) * 256);
   localparam logic signed [7:0]    DIFF_MAX = 8'(2 * DIM * DIM);

   // sequencer states
   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_SQ     = 5'd2;
   localparam logic [4:0] S_RHS    = 5'd3;
   localparam logic [4:0] S_AHEAD  = 5'd4;
   localparam logic [4:0] S_SENSE  = 5'd5;
   localparam logic [4:0] S_WRAP   = 5'd6;
   localparam logic [4:0] S_WRD    = 5'd7;
   localparam logic [4:0] S_WDAT   = 5'd8;
   localparam logic [4:0] S_WDIV   = 5'd9;
   localparam logic [4:0] S_CMP    = 5'd10;
   localparam logic [4:0] S_RMUL   = 5'd11;
   localparam logic [4:0] S_RSUM   = 5'd12;
   localparam logic [4:0] S_SLOW1  = 5'd13;
   localparam logic [4:0] S_SLOW2  = 5'd14;
   localparam logic [4:0] S_MOVE   = 5'd15;
   localparam logic [4:0] S_PAINT  = 5'd16;
   localparam logic [4:0] S_PRD    = 5'd17;
   localparam logic [4:0] S_PDAT   = 5'd18;
   localparam logic [4:0] S_EVAP   = 5'd19;
   localparam logic [4:0] S_EDRAIN = 5'd20;
   localparam logic [4:0] S_DONE   = 5'd21;

   // pixel address from a wrapped coordinate pair
   function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
      return AW'(y) * AW'(IMAGE_WIDTH) + AW'(x);
   endfunction

   // q.8 to pixel, truncating toward zero
   function automatic logic signed [CW-1:0] trunc_q8(input logic signed [18:0] s);
      logic signed [18:0] m;
      m = -s;
      if (s >= 19'sd0) return CW'(s >>> 8);
      return CW'(-(m >>> 8));
   endfunction

   // position plus q.13 velocity, rounded to q.8 and wrapped at the edge
   function automatic logic signed [23:0] move_axis(input logic [16:0] p,
                                                   input logic signed [15:0] v,
                                                   input logic signed [23:0] lim);
      logic signed [23:0] t;
      logic signed [23:0] n;
      t = $signed({2'b00, p, 5'b00000}) + v + 24'sd16;
      n = t >>> 5;
      if (n > lim) n = 24'sd0;
      else if (n < 24'sd0) n = lim;
      return n;
   endfunction

   function automatic logic [7:0] decay_ch(input logic [7:0] c, input logic [7:0] b,
                                           input logic [16:0] rate, input logic [16:0] inv);
      logic [25:0] acc;
      acc = 26'(c) * 26'(rate) + 26'(b) * 26'(inv);
      return acc[23:16];
   endfunction

   // control
   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          ev_v_ff, ev_v_in;

   // registers
   logic [16:0] decay_ff, decay_in;
   logic [4:0]  sens_ff, sens_in;
   logic [23:0] bg_ff, bg_in;

   // captured request and working values
   logic [1:0]         kind_ff, kind_in;
   logic [16:0]        px_ff, px_in, py_ff, py_in;
   logic signed [15:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [23:0]        col_ff, col_in;
   logic [1:0]         turn_ff, turn_in;
   logic signed [14:0] rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic [30:0]        vx2_ff, vx2_in, vy2_ff, vy2_in;
   logic [9:0]         sl2_ff, sl2_in;
   logic [31:0]        q_ff, q_in;
   logic [42:0]        rhsx_ff, rhsx_in, rhsy_ff, rhsy_in;
   logic [4:0]         k_ff, k_in, bx_ff, bx_in, by_ff, by_in;
   logic [10:0]        k2_ff, k2_in;
   logic signed [CW-1:0] lane_ff [4];
   logic signed [CW-1:0] lane_in [4];
   logic               wsel_ff, wsel_in;
   logic [OW-1:0]      oi_ff, oi_in, oj_ff, oj_in;
   logic signed [7:0]  diff_ff, diff_in;
   logic               dir_ff, dir_in, rret_ff, rret_in;
   logic signed [31:0] pxc_ff, pxc_in, pys_ff, pys_in, pyc_ff, pyc_in, pxs_ff, pxs_in;
   logic signed [23:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [23:0]        pix_ff, pix_in;
   logic [XW-1:0]      ex_ff, ex_in;
   logic [YW-1:0]      ey_ff, ey_in;
   logic [AW-1:0]      ev_addr_ff, ev_addr_in;

   // response register
   logic [16:0]        rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic signed [15:0] rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;
   logic [23:0]        rsp_pix_ff, rsp_pix_in;

   // ram ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [23:0]   ram_wdata, ram_rdata;

   // datapath helpers
   logic                 req_acc, rsp_free, div_start, div_done, div_match;
   logic                 q_zero, lanes_ok, win_last;
   logic signed [6:0]    lx_s, ly_s;
   logic signed [18:0]   s_lx, s_ly, s_rx, s_ry;
   logic signed [CW-1:0] fx, fy;
   logic [16:0]          rate;
   logic [16:0]          inv;
   logic signed [32:0]   rot_x, rot_y;
   logic [31:0]          v2_sum;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // sensor offsets and sensor points
   always_comb begin
      q_zero = (q_ff == 32'd0);
      lx_s = q_zero ? 7'sd0 : (vx_ff[15] ? -$signed({2'b00, bx_ff}) : $signed({2'b00, bx_ff}));
      ly_s = q_zero ? 7'sd0 : (vy_ff[15] ? -$signed({2'b00, by_ff}) : $signed({2'b00, by_ff}));
      s_lx = $signed({2'b00, px_ff}) + (lx_s - ly_s) * DIAG_Q8;
      s_ly = $signed({2'b00, py_ff}) + (ly_s + lx_s) * DIAG_Q8;
      s_rx = $signed({2'b00, px_ff}) + (lx_s + ly_s) * DIAG_Q8;
      s_ry = $signed({2'b00, py_ff}) + (ly_s - lx_s) * DIAG_Q8;
   end

   // window pixel coordinate, neighbor of a wrapped centre
   always_comb begin
      fx = (wsel_ff ? lane_ff[2] : lane_ff[0]) + $signed(CW'(oi_ff)) - HALF_S;
      fy = (wsel_ff ? lane_ff[3] : lane_ff[1]) + $signed(CW'(oj_ff)) - HALF_S;
      if (fx < 0) fx = fx + WS;
      else if (fx >= WS) fx = fx - WS;
      if (fy < 0) fy = fy + HS;
      else if (fy >= HS) fy = fy - HS;
      win_last = wsel_ff && (oi_ff == OW'(DIM - 1)) && (oj_ff == OW'(DIM - 1));
   end

   always_comb begin
      lanes_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (lane_ff[i] < 0 || lane_ff[i] >= ((i % 2 == 0) ? WS : HS)) lanes_ok = 1'b0;
      end
   end

   assign rate   = (decay_ff > ONE_Q16) ? ONE_Q16 : decay_ff;
   assign inv    = ONE_Q16 - rate;
   assign rot_x  = dir_ff ? (33'(pxc_ff) - 33'(pys_ff)) : (33'(pxc_ff) + 33'(pys_ff));
   assign rot_y  = dir_ff ? (33'(pyc_ff) + 33'(pxs_ff)) : (33'(pyc_ff) - 33'(pxs_ff));
   assign v2_sum = 32'(vx2_ff) + 32'(vy2_ff);
   assign div_start = (state_ff == S_WDAT) && (ram_rdata != bg_ff);

   // ram port control: sweep, paint and evaporate write-back never overlap,
   // and every read of an entry comes after its last write, never in the same cycle
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = BG_RESET;
      ram_raddr = pix_addr(fy[YW-1:0], fx[XW-1:0]);
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
      end else if (state_ff == S_PAINT) begin
         ram_we    = 1'b1;
         ram_waddr = pix_addr(ny_ff[YW+7:8], nx_ff[XW+7:8]);
         ram_wdata = col_ff;
      end else if (ev_v_ff) begin
         ram_we    = 1'b1;
         ram_waddr = ev_addr_ff;
         ram_wdata = {decay_ch(ram_rdata[23:16], bg_ff[23:16], rate, inv),
                      decay_ch(ram_rdata[15:8], bg_ff[15:8], rate, inv),
                      decay_ch(ram_rdata[7:0], bg_ff[7:0], rate, inv)};
      end
      if (state_ff == S_PRD) begin
         ram_raddr = pix_addr(lane_ff[1][YW-1:0], lane_ff[0][XW-1:0]);
      end else if (state_ff == S_EVAP) begin
         ram_raddr = pix_addr(ey_ff, ex_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;     ev_v_in = 1'b0;
      decay_in = decay_ff;   sens_in = sens_ff;   bg_in = bg_ff;
      kind_in = kind_ff;     px_in = px_ff;       py_in = py_ff;
      vx_in = vx_ff;         vy_in = vy_ff;       col_in = col_ff;
      turn_in = turn_ff;     rvx_in = rvx_ff;     rvy_in = rvy_ff;
      vx2_in = vx2_ff;       vy2_in = vy2_ff;     sl2_in = sl2_ff;
      q_in = q_ff;           rhsx_in = rhsx_ff;   rhsy_in = rhsy_ff;
      k_in = k_ff;           k2_in = k2_ff;       bx_in = bx_ff;  by_in = by_ff;
      lane_in = lane_ff;     wsel_in = wsel_ff;   oi_in = oi_ff;  oj_in = oj_ff;
      diff_in = diff_ff;     dir_in = dir_ff;     rret_in = rret_ff;
      pxc_in = pxc_ff;       pys_in = pys_ff;     pyc_in = pyc_ff; pxs_in = pxs_ff;
      nx_in = nx_ff;         ny_in = ny_ff;       pix_in = pix_ff;
      ex_in = ex_ff;         ey_in = ey_ff;       ev_addr_in = ev_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_px_in = rsp_px_ff; rsp_py_in = rsp_py_ff;
      rsp_vx_in = rsp_vx_ff; rsp_vy_in = rsp_vy_ff; rsp_pix_in = rsp_pix_ff;

      if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_DECAY:  decay_in = csr_ch.data[16:0];
            CSR_SENSOR: sens_in  = csr_ch.data[4:0];
            CSR_BG:     bg_in    = csr_ch.data;
            default:    ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               kind_in = req_ch.req_type;
               px_in = req_ch.pos_x;       py_in = req_ch.pos_y;
               vx_in = req_ch.vel_x;       vy_in = req_ch.vel_y;
               col_in = req_ch.agent_color; turn_in = req_ch.turn_choice;
               rvx_in = req_ch.random_vx;  rvy_in = req_ch.random_vy;
               wsel_in = 1'b0; oi_in = '0; oj_in = '0; diff_in = 8'sd0;
               lane_in[0] = $signed(CW'(req_ch.pixel_x));
               lane_in[1] = $signed(CW'(req_ch.pixel_y));
               lane_in[2] = '0;
               lane_in[3] = '0;
               ex_in = XW'(1);
               ey_in = YW'(1);
               case (req_ch.req_type)
                  REQ_STEP: state_in = S_SQ;
                  REQ_EVAP: state_in = S_EVAP;
                  REQ_READ: state_in = S_WRAP;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SQ: begin
            vx2_in = 31'(vx_ff) * 31'(vx_ff);
            vy2_in = 31'(vy_ff) * 31'(vy_ff);
            sl2_in = 10'(sens_ff) * 10'(sens_ff);
            state_in = S_RHS;
         end
         S_RHS: begin
            q_in = v2_sum;
            rhsx_in = 43'(sl2_ff) * 43'(vx2_ff);
            rhsy_in = 43'(sl2_ff) * 43'(vy2_ff);
            k_in = 5'd1; k2_in = 11'd1; bx_in = 5'd0; by_in = 5'd0;
            state_in = (sens_ff == 5'd0) ? S_SENSE : S_AHEAD;
         end
         S_AHEAD: begin
            // largest k up to the sensor distance with k*k*q <= sl*sl*v*v
            if (43'(k2_ff) * 43'(q_ff) <= rhsx_ff) bx_in = k_ff;
            if (43'(k2_ff) * 43'(q_ff) <= rhsy_ff) by_in = k_ff;
            k_in = k_ff + 5'd1;
            k2_in = k2_ff + {5'd0, k_ff, 1'b0} + 11'd1;
            if (k_ff == sens_ff) state_in = S_SENSE;
         end
         S_SENSE: begin
            lane_in[0] = trunc_q8(s_lx);
            lane_in[1] = trunc_q8(s_ly);
            lane_in[2] = trunc_q8(s_rx);
            lane_in[3] = trunc_q8(s_ry);
            state_in = S_WRAP;
         end
         S_WRAP: begin
            for (int i = 0; i < 4; i++) begin
               if (lane_ff[i] < 0) lane_in[i] = lane_ff[i] + ((i % 2 == 0) ? WS : HS);
               else if (lane_ff[i] >= ((i % 2 == 0) ? WS : HS))
                  lane_in[i] = lane_ff[i] - ((i % 2 == 0) ? WS : HS);
            end
            if (lanes_ok) state_in = (kind_ff == REQ_READ) ? S_PRD : S_WRD;
         end
         S_WRD: state_in = S_WDAT;
         S_WDAT, S_WDIV: begin
            if (state_ff == S_WDAT && div_start) begin
               state_in = S_WDIV;
            end else if (state_ff == S_WDIV && !div_done) begin
               state_in = S_WDIV;
            end else begin
               // left window adds its score, right window subtracts
               if (state_ff == S_WDIV) begin
                  diff_in = (div_match != wsel_ff) ? diff_ff + 8'sd1 : diff_ff - 8'sd1;
               end
               state_in = win_last ? S_CMP : S_WRD;
               if (oj_ff == OW'(DIM - 1)) begin
                  oj_in = '0;
                  if (oi_ff == OW'(DIM - 1)) begin
                     oi_in = '0;
                     wsel_in = 1'b1;
                  end else begin
                     oi_in = oi_ff + OW'(1);
                  end
               end else begin
                  oj_in = oj_ff + OW'(1);
               end
            end
         end
         S_CMP: begin
            rret_in = 1'b1;
            dir_in = (diff_ff > 8'sd0);
            state_in = (diff_ff == 8'sd0) ? S_SLOW1 : S_RMUL;
         end
         S_RMUL: begin
            pxc_in = vx_ff * ROT_COS;
            pys_in = vy_ff * ROT_SIN;
            pyc_in = vy_ff * ROT_COS;
            pxs_in = vx_ff * ROT_SIN;
            state_in = S_RSUM;
         end
         S_RSUM: begin
            vx_in = sat16((34'(rot_x) + 34'sd16384) >>> 15);
            vy_in = sat16((34'(rot_y) + 34'sd16384) >>> 15);
            state_in = rret_ff ? S_SLOW1 : S_MOVE;
         end
         S_SLOW1: begin
            vx2_in = 31'(vx_ff) * 31'(vx_ff);
            vy2_in = 31'(vy_ff) * 31'(vy_ff);
            state_in = S_SLOW2;
         end
         S_SLOW2: begin
            rret_in = 1'b0;
            state_in = S_MOVE;
            if (v2_sum <= SLOW_SQ) begin
               vx_in = {rvx_ff[14], rvx_ff};
               vy_in = {rvy_ff[14], rvy_ff};
            end else if (turn_ff == TURN_POS) begin
               dir_in = 1'b1;
               state_in = S_RMUL;
            end else if (turn_ff == TURN_NEG) begin
               dir_in = 1'b0;
               state_in = S_RMUL;
            end
         end
         S_MOVE: begin
            nx_in = move_axis(px_ff, vx_ff, LIM_X);
            ny_in = move_axis(py_ff, vy_ff, LIM_Y);
            state_in = S_PAINT;
         end
         S_PAINT: state_in = S_DONE;
         S_PRD:   state_in = S_PDAT;
         S_PDAT: begin
            pix_in = ram_rdata;
            state_in = S_DONE;
         end
         S_EVAP: begin
            // read one interior pixel a cycle, write it back decayed in the following cycle
            ev_v_in = 1'b1;
            ev_addr_in = ram_raddr;
            if (ex_ff == XW'(IMAGE_WIDTH - 2)) begin
               ex_in = XW'(1);
               ey_in = ey_ff + YW'(1);
               if (ey_ff == YW'(IMAGE_HEIGHT - 2)) state_in = S_EDRAIN;
            end else begin
               ex_in = ex_ff + XW'(1);
            end
         end
         S_EDRAIN: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_px_in = '0; rsp_py_in = '0; rsp_vx_in = '0; rsp_vy_in = '0;
               rsp_pix_in = '0;
               if (kind_ff == REQ_STEP) begin
                  rsp_px_in = nx_ff[16:0];
                  rsp_py_in = ny_ff[16:0];
                  rsp_vx_in = vx_ff;
                  rsp_vy_in = vy_ff;
               end else if (kind_ff == REQ_READ) begin
                  rsp_pix_in = pix_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ev_v_ff      <= 1'b0;
         decay_ff     <= DECAY_RESET;
         sens_ff      <= SENSOR_RESET;
         bg_ff        <= BG_RESET;
         diff_ff      <= 8'sd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_v_ff      <= ev_v_in;
         decay_ff     <= decay_in;
         sens_ff      <= sens_in;
         bg_ff        <= bg_in;
         diff_ff      <= diff_in;
      end
      kind_ff <= kind_in;  px_ff <= px_in;    py_ff <= py_in;
      vx_ff <= vx_in;      vy_ff <= vy_in;    col_ff <= col_in;
      turn_ff <= turn_in;  rvx_ff <= rvx_in;  rvy_ff <= rvy_in;
      vx2_ff <= vx2_in;    vy2_ff <= vy2_in;  sl2_ff <= sl2_in;
      q_ff <= q_in;        rhsx_ff <= rhsx_in; rhsy_ff <= rhsy_in;
      k_ff <= k_in;        k2_ff <= k2_in;    bx_ff <= bx_in;   by_ff <= by_in;
      lane_ff <= lane_in;  wsel_ff <= wsel_in; oi_ff <= oi_in;  oj_ff <= oj_in;
      dir_ff <= dir_in;    rret_ff <= rret_in;
      pxc_ff <= pxc_in;    pys_ff <= pys_in;  pyc_ff <= pyc_in; pxs_ff <= pxs_in;
      nx_ff <= nx_in;      ny_ff <= ny_in;    pix_ff <= pix_in;
      ex_ff <= ex_in;      ey_ff <= ey_in;    ev_addr_ff <= ev_addr_in;
      rsp_px_ff <= rsp_px_in; rsp_py_ff <= rsp_py_in;
      rsp_vx_ff <= rsp_vx_in; rsp_vy_ff <= rsp_vy_in; rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.new_pos_x   = rsp_px_ff;
   assign rsp_ch.new_pos_y   = rsp_py_ff;
   assign rsp_ch.new_vel_x   = rsp_vx_ff;
   assign rsp_ch.new_vel_y   = rsp_vy_ff;
   assign rsp_ch.pixel_color = rsp_pix_ff;

   sate_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
   ) u_trail (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sate_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .pixel (ram_rdata),
      .favor (col_ff),
      .done  (div_done),
      .match (div_match)
   );

   // no request is taken during the reset sweep
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request taken during ram sweep");

   // ram writes only from the sweep, the paint or the evaporate write-back
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_PAINT || ev_v_ff))
      else $error("unexpected ram write");

   // window score difference stays within two full windows
   a_diff_bound: assert property (@(posedge clock) disable iff (reset)
      (diff_ff <= DIFF_MAX) && (diff_ff >= -DIFF_MAX))
      else $error("score difference out of range");

   // a finished request loads the response register and frees the engine
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("response not loaded on completion");

endmodule
